// ===== rtl/core/edid_displayid_container_id_finder_defines.svh =====
// ----------------------------------------------------------------------------
// EDID DisplayID Container ID finder: assertion macros
// Shared concurrent assertion forms. Each use sits inside a module that has
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef EDID_DISPLAYID_CONTAINER_ID_FINDER_DEFINES_SVH
`define EDID_DISPLAYID_CONTAINER_ID_FINDER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define EDIDCID_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define EDIDCID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define EDIDCID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/edidcid_pkg.sv =====
// ----------------------------------------------------------------------------
// edidcid_pkg
// Constants and shared types of the EDID DisplayID Container ID finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edidcid_pkg;

    localparam logic [15:0] OFFSET_LIMIT     = 16'd32768;
    localparam logic [15:0] EXT_COUNT_OFFSET = 16'd126;
    localparam logic [15:0] BLOCK_SIZE       = 16'd128;
    localparam logic [7:0]  TAG_DISPLAYID    = 8'h70;
    localparam logic [7:0]  TAG_CONTAINER_ID = 8'h29;
    localparam logic [4:0]  ID_BYTES         = 5'd16;
    localparam logic [6:0]  DATA_END_MAX     = 7'd127;
    localparam logic [8:0]  FIRST_HEADER     = 9'd5;
    localparam logic [6:0]  LEN_OFFSET       = 7'd2;

    // Per-byte commands from the block walker to the capture unit.
    typedef struct packed {
        logic take;   // a counted byte arrived
        logic start;  // a Container ID payload begins with the next byte
        logic clear;  // end of image, return to reset
    } capture_ctrl_t;

    // Capture state as it stands after the current byte, before any clear.
    typedef struct packed {
        logic        found;
        logic [63:0] id_high;
        logic [63:0] id_low;
    } capture_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/edid_displayid_container_id_finder.sv =====
// ----------------------------------------------------------------------------
// edid_displayid_container_id_finder
// Streams an EDID image byte by byte and reports the first nonzero DisplayID
// Container ID found in its extension blocks.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_ready) carries one EDID byte per request,
// in ascending offset order, with last set on the final byte of the image.
// The output channel (out_valid / out_ready) carries one result request per
// image: found, id_high and id_low, given on the cycle after the last byte
// is accepted. A new byte is accepted every cycle while in_ready is high,
// as the block walker and the capture shift register each make a single
// registered pass per byte. The result sits in an output register, so bytes
// of the next image keep flowing while the result waits. Only when a result
// is still held and a second last byte arrives does in_ready drop, until
// out_ready takes the held result.
// Reset (rst_n low) clears the walker, the capture unit and the output
// valid flag at once; no clearing pass is needed. After each result the
// internal state returns to its reset values for the next image.
// Bytes past 32768 are counted as ignored, though their last flag still
// yields the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "edid_displayid_container_id_finder_defines.svh"

module edid_displayid_container_id_finder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  edid_byte,
    input  wire logic        last,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             found,
    output logic [63:0]      id_high,
    output logic [63:0]      id_low,
    output logic             out_valid,
    input  wire logic        out_ready
);

    // Block walker state.
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  ext_reg, ext_next;
    logic        is_did_reg, is_did_next;
    logic [6:0]  data_end_reg, data_end_next;
    logic [8:0]  hdr_off_reg, hdr_off_next;
    logic [7:0]  tag_reg, tag_next;
    logic        hdr_busy_reg, hdr_busy_next;

    // Result register.
    logic        out_valid_reg;
    logic        found_reg;
    logic [63:0] id_high_reg;
    logic [63:0] id_low_reg;

    edidcid_pkg::capture_ctrl_t   cap_ctrl;
    edidcid_pkg::capture_status_t cap_status;

    logic        in_acc;
    logic        counted;
    logic [15:0] rel_off;
    logic [7:0]  blk_idx;
    logic [6:0]  blk_pos;
    logic [8:0]  data_end_raw;
    logic [7:0]  ext_cur;
    logic [15:0] need_bytes;
    logic        result_ok;

    // Only a last byte has to wait for the held result to leave.
    assign in_ready = !out_valid_reg || out_ready || !last;
    assign in_acc   = in_valid && in_ready;
    assign counted  = in_acc && (offset_reg < edidcid_pkg::OFFSET_LIMIT);

    // Position inside the extension area; only used once offset is 128 or more.
    assign rel_off      = offset_reg - edidcid_pkg::BLOCK_SIZE;
    assign blk_idx      = rel_off[14:7];
    assign blk_pos      = rel_off[6:0];
    assign data_end_raw = 9'd5 + {1'b0, edid_byte};

    always_comb
    begin
        offset_next   = offset_reg;
        ext_next      = ext_reg;
        is_did_next   = is_did_reg;
        data_end_next = data_end_reg;
        hdr_off_next  = hdr_off_reg;
        tag_next      = tag_reg;
        hdr_busy_next = hdr_busy_reg;
        cap_ctrl.take  = counted;
        cap_ctrl.start = 1'b0;
        cap_ctrl.clear = in_acc && last;

        if (counted)
        begin
            offset_next = offset_reg + 16'd1;
            if (offset_reg == edidcid_pkg::EXT_COUNT_OFFSET)
            begin
                ext_next = edid_byte;
            end
            if (offset_reg >= edidcid_pkg::BLOCK_SIZE)
            begin
                if (blk_pos == 7'd0)
                begin
                    // Block tag byte: only extensions within the count qualify.
                    is_did_next   = (edid_byte == edidcid_pkg::TAG_DISPLAYID) &&
                                    (blk_idx < ext_reg);
                    hdr_off_next  = edidcid_pkg::FIRST_HEADER;
                    data_end_next = 7'd0;
                    hdr_busy_next = 1'b0;
                end
                else if (is_did_reg)
                begin
                    if (blk_pos == edidcid_pkg::LEN_OFFSET)
                    begin
                        data_end_next = (data_end_raw > {2'b0, edidcid_pkg::DATA_END_MAX})
                                      ? edidcid_pkg::DATA_END_MAX : data_end_raw[6:0];
                    end
                    if (!hdr_busy_reg && ({2'b0, blk_pos} == hdr_off_reg) &&
                        (({1'b0, hdr_off_reg} + 10'd3) <= {3'b0, data_end_next}))
                    begin
                        hdr_busy_next = 1'b1;
                        tag_next      = edid_byte;
                    end
                    else if (hdr_busy_reg &&
                             ({3'b0, blk_pos} == ({1'b0, hdr_off_reg} + 10'd2)))
                    begin
                        hdr_busy_next  = 1'b0;
                        cap_ctrl.start = (tag_reg == edidcid_pkg::TAG_CONTAINER_ID) &&
                                         (edid_byte >= {3'b0, edidcid_pkg::ID_BYTES});
                        hdr_off_next   = hdr_off_reg + 9'd3 + {1'b0, edid_byte};
                    end
                end
            end
        end

        // End of image: everything goes back to reset for the next one.
        if (in_acc && last)
        begin
            offset_next   = '0;
            ext_next      = '0;
            is_did_next   = 1'b0;
            data_end_next = '0;
            hdr_off_next  = edidcid_pkg::FIRST_HEADER;
            tag_next      = '0;
            hdr_busy_next = 1'b0;
        end
    end

    // The extension count as it stands after the current byte, before the
    // end-of-image clear.
    assign ext_cur = (counted && (offset_reg == edidcid_pkg::EXT_COUNT_OFFSET))
                   ? edid_byte : ext_reg;

    // The image must be long enough to hold every announced extension block.
    assign need_bytes = {1'b0, ext_cur, 7'd0} + edidcid_pkg::BLOCK_SIZE;
    assign result_ok  = cap_status.found && (ext_cur != 8'd0) &&
                        ((counted ? offset_reg + 16'd1 : offset_reg) >= need_bytes);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            ext_reg      <= '0;
            is_did_reg   <= 1'b0;
            data_end_reg <= '0;
            hdr_off_reg  <= edidcid_pkg::FIRST_HEADER;
            tag_reg      <= '0;
            hdr_busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg   <= offset_next;
            ext_reg      <= ext_next;
            is_did_reg   <= is_did_next;
            data_end_reg <= data_end_next;
            hdr_off_reg  <= hdr_off_next;
            tag_reg      <= tag_next;
            hdr_busy_reg <= hdr_busy_next;
            if (in_acc && last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && last)
        begin
            found_reg   <= result_ok;
            id_high_reg <= result_ok ? cap_status.id_high : 64'd0;
            id_low_reg  <= result_ok ? cap_status.id_low : 64'd0;
        end
    end

    edidcid_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .edid_byte (edid_byte),
        .ctrl      (cap_ctrl),
        .status    (cap_status)
    );

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign id_high   = id_high_reg;
    assign id_low    = id_low_reg;

    `EDIDCID_ASSERT(a_offset_sat, offset_reg <= edidcid_pkg::OFFSET_LIMIT,
        "byte counter past its limit")
    `EDIDCID_ASSERT_IMPL(a_found_nonzero, out_valid_reg && found_reg,
        (id_high_reg | id_low_reg) != 64'd0, "found result with an all-zero ID")
    `EDIDCID_ASSERT_IMPL(a_miss_zero, out_valid_reg && !found_reg,
        (id_high_reg == 64'd0) && (id_low_reg == 64'd0), "missed result with nonzero ID")
    `EDIDCID_ASSERT_NEXT(a_last_result, in_acc && last,
        out_valid_reg && (offset_reg == 16'd0), "last byte gave no result")

endmodule

`default_nettype wire

// ===== rtl/core/edidcid_capture.sv =====
// ----------------------------------------------------------------------------
// edidcid_capture
// Collects the 16 payload bytes of a Container ID data block, keeps one
// overlapping payload pending, and freezes on the first nonzero ID.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "edid_displayid_container_id_finder_defines.svh"

module edidcid_capture (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [7:0]                  edid_byte,
    input  wire edidcid_pkg::capture_ctrl_t  ctrl,
    output edidcid_pkg::capture_status_t     status
);

    logic [63:0] cap_hi_reg, cap_hi_next;
    logic [63:0] cap_lo_reg, cap_lo_next;
    logic [4:0]  rem_reg, rem_next;
    logic        nz_reg, nz_next;
    logic        found_reg, found_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [4:0]  pend_count_reg, pend_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_hi_reg     <= '0;
            cap_lo_reg     <= '0;
            rem_reg        <= '0;
            nz_reg         <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_count_reg <= '0;
        end
        else
        begin
            cap_hi_reg     <= cap_hi_next;
            cap_lo_reg     <= cap_lo_next;
            rem_reg        <= rem_next;
            nz_reg         <= nz_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            pend_count_reg <= pend_count_next;
        end
    end

    always_comb
    begin
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  rem;
        logic        nz;
        logic        f;
        logic        pv;
        logic [4:0]  pc;

        hi  = cap_hi_reg;
        lo  = cap_lo_reg;
        rem = rem_reg;
        nz  = nz_reg;
        f   = found_reg;
        pv  = pend_valid_reg;
        pc  = pend_count_reg;

        // Shift in the arriving byte of a running capture.
        if (ctrl.take && !f && (rem != 5'd0))
        begin
            hi  = {hi[55:0], lo[63:56]};
            lo  = {lo[55:0], edid_byte};
            if (edid_byte != 8'd0)
            begin
                nz = 1'b1;
            end
            rem = rem - 5'd1;
            if (pv)
            begin
                pc = pc + 5'd1;
            end
            if (rem == 5'd0)
            begin
                if (nz)
                begin
                    f  = 1'b1;
                    pv = 1'b0;
                end
                else if (pv)
                begin
                    // The shared bytes were all zero, so the pending payload
                    // resumes from an empty shift register.
                    rem = edidcid_pkg::ID_BYTES - pc;
                    hi  = '0;
                    lo  = '0;
                    nz  = 1'b0;
                    pv  = 1'b0;
                end
            end
        end

        // A new payload either starts now or waits behind the running one.
        if (ctrl.start && !f)
        begin
            if (rem == 5'd0)
            begin
                rem = edidcid_pkg::ID_BYTES;
                hi  = '0;
                lo  = '0;
                nz  = 1'b0;
            end
            else
            begin
                pv = 1'b1;
                pc = 5'd0;
            end
        end

        status.found   = f;
        status.id_high = hi;
        status.id_low  = lo;

        if (ctrl.clear)
        begin
            cap_hi_next     = '0;
            cap_lo_next     = '0;
            rem_next        = '0;
            nz_next         = 1'b0;
            found_next      = 1'b0;
            pend_valid_next = 1'b0;
            pend_count_next = '0;
        end
        else
        begin
            cap_hi_next     = hi;
            cap_lo_next     = lo;
            rem_next        = rem;
            nz_next         = nz;
            found_next      = f;
            pend_valid_next = pv;
            pend_count_next = pc;
        end
    end

    `EDIDCID_ASSERT(a_rem_range, rem_reg <= edidcid_pkg::ID_BYTES, "capture count out of range")
    `EDIDCID_ASSERT_IMPL(a_pend_needs_run, pend_valid_reg, rem_reg != 5'd0,
        "pending capture without a running one")
    `EDIDCID_ASSERT_NEXT(a_found_frozen, found_reg && !ctrl.clear,
        $stable(cap_hi_reg) && $stable(cap_lo_reg) && found_reg, "found ID changed")

endmodule

`default_nettype wire

// ===== test/tb_edid_displayid_container_id_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for edid_displayid_container_id_finder
// Streams EDID images, a full directed one and many short ones, into the
// finder with random idle and stall patterns on both channels. A built-in
// model of the DisplayID walk predicts one report per image, and each report
// that the block returns is checked field by field against it.
// ----------------------------------------------------------------------------

module tb_edid_displayid_container_id_finder;

    // The longest receiver hold-off, in cycles, used to fill up the block.
    localparam int LONG_STALL_CYCLES = 400;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the walker and capture state, turns
    // every accepted request into an expected report at the end of an image,
    // and compares the reports that come out of the block.
    // ------------------------------------------------------------------------
    class container_id_scoreboard;

        typedef struct {
            bit        found;
            bit [63:0] id_high;
            bit [63:0] id_low;
        } report_t;

        report_t expected_reports[$];
        int      errors;

        int unsigned offs;
        bit [7:0]    ext_count;
        bit          in_displayid;
        int unsigned data_end;
        int unsigned next_hdr;
        bit [7:0]    hdr_tag;
        bit          hdr_busy;
        bit [127:0]  cap;
        int unsigned cap_left;
        bit          cap_nonzero;
        bit          have_id;
        bit [127:0]  id_bytes;
        bit          pend;
        int unsigned pend_cnt;

        function new();
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            offs         = 0;
            ext_count    = '0;
            in_displayid = 1'b0;
            data_end     = 0;
            next_hdr     = edidcid_pkg::FIRST_HEADER;
            hdr_tag      = '0;
            hdr_busy     = 1'b0;
            cap          = '0;
            cap_left     = 0;
            cap_nonzero  = 1'b0;
            have_id      = 1'b0;
            id_bytes     = '0;
            pend         = 1'b0;
            pend_cnt     = 0;
        endfunction

        // Shift one byte into a running capture. When it completes, a
        // nonzero ID is kept; an all-zero one hands over to a pending one.
        function void shift_in(input bit [7:0] v);
            if (have_id || cap_left == 0)
                return;
            cap = {cap[119:0], v};
            if (v != 8'd0)
                cap_nonzero = 1'b1;
            cap_left--;
            if (pend)
                pend_cnt++;
            if (cap_left == 0) begin
                if (cap_nonzero) begin
                    have_id  = 1'b1;
                    id_bytes = cap;
                    pend     = 1'b0;
                end
                else if (pend) begin
                    cap_left    = edidcid_pkg::ID_BYTES - pend_cnt;
                    cap         = '0;
                    cap_nonzero = 1'b0;
                    pend        = 1'b0;
                end
            end
        endfunction

        function void open_capture();
            if (have_id)
                return;
            if (cap_left == 0) begin
                cap_left    = edidcid_pkg::ID_BYTES;
                cap         = '0;
                cap_nonzero = 1'b0;
            end
            else begin
                pend     = 1'b1;
                pend_cnt = 0;
            end
        endfunction

        function void note_byte(input bit [7:0] v, input bit is_last);
            int unsigned o;
            int unsigned blk;
            int unsigned p;
            int unsigned vi;
            report_t     rep;
            vi = v;
            if (offs < edidcid_pkg::OFFSET_LIMIT) begin
                o = offs;
                shift_in(v);
                if (o == edidcid_pkg::EXT_COUNT_OFFSET)
                    ext_count = v;
                if (o >= edidcid_pkg::BLOCK_SIZE) begin
                    blk = (o - edidcid_pkg::BLOCK_SIZE) >> 7;
                    p   = (o - edidcid_pkg::BLOCK_SIZE) & 127;
                    if (p == 0) begin
                        in_displayid = (v == edidcid_pkg::TAG_DISPLAYID) &&
                                       (blk < ext_count);
                        next_hdr     = edidcid_pkg::FIRST_HEADER;
                        data_end     = 0;
                        hdr_busy     = 1'b0;
                    end
                    else if (in_displayid) begin
                        if (p == edidcid_pkg::LEN_OFFSET)
                            data_end = (edidcid_pkg::FIRST_HEADER + vi >
                                        edidcid_pkg::DATA_END_MAX) ?
                                       edidcid_pkg::DATA_END_MAX :
                                       edidcid_pkg::FIRST_HEADER + vi;
                        if (!hdr_busy && p == next_hdr && next_hdr + 3 <= data_end) begin
                            hdr_busy = 1'b1;
                            hdr_tag  = v;
                        end
                        else if (hdr_busy && p == next_hdr + 2) begin
                            hdr_busy = 1'b0;
                            if (hdr_tag == edidcid_pkg::TAG_CONTAINER_ID &&
                                vi >= edidcid_pkg::ID_BYTES)
                                open_capture();
                            next_hdr = (next_hdr + 3 + vi) & 'h1FF;
                        end
                    end
                end
                offs++;
            end
            if (is_last) begin
                rep.found   = have_id && ext_count != 0 &&
                              offs >= edidcid_pkg::BLOCK_SIZE +
                                      edidcid_pkg::BLOCK_SIZE * ext_count;
                rep.id_high = rep.found ? id_bytes[127:64] : 64'd0;
                rep.id_low  = rep.found ? id_bytes[63:0] : 64'd0;
                expected_reports.push_back(rep);
                clear_walk();
            end
        endfunction

        function void check_report(input logic got_found, input logic [63:0] got_high,
                                   input logic [63:0] got_low);
            report_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t ns: report with no image pending: found=%0b id_high=%h id_low=%h",
                         $time, got_found, got_high, got_low);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got_found !== want.found) begin
                $display("%0t ns: found mismatch, expected %0b, got %0b",
                         $time, want.found, got_found);
                errors++;
            end
            if (got_high !== want.id_high) begin
                $display("%0t ns: id_high mismatch, expected %h, got %h",
                         $time, want.id_high, got_high);
                errors++;
            end
            if (got_low !== want.id_low) begin
                $display("%0t ns: id_low mismatch, expected %h, got %h",
                         $time, want.id_low, got_low);
                errors++;
            end
        endfunction

        function int waiting();
            return expected_reports.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  edid_byte = 8'd0;
    logic        last = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        found;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic        out_valid;
    logic        out_ready = 1'b0;

    always #10 clk = ~clk;

    edid_displayid_container_id_finder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .edid_byte (edid_byte),
        .last      (last),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .found     (found),
        .id_high   (id_high),
        .id_low    (id_low),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    container_id_scoreboard id_board = new();

    // Percentages that set how often the sender idles and the receiver
    // stalls; the stimulus changes them from phase to phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The main process toggles the request bit to ask for one long
    // receiver hold-off; the receiver process answers with its own copy so
    // that each variable has a single writer.
    bit long_stall_req = 1'b0;
    bit long_stall_ack = 1'b0;

    // The EDID image that is about to be streamed.
    bit [7:0] img[$];

    // ------------------------------------------------------------------------
    // Receiver: drives out_ready at the falling edge. A long hold-off is
    // counted here, in cycles, independent of what the sender is doing.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (long_stall_req != long_stall_ack) begin
                long_stall_ack = long_stall_req;
                stall_left     = LONG_STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Every report that the block hands over is checked at the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            id_board.check_report(found, id_high, id_low);
    end

    // ------------------------------------------------------------------------
    // Image building helpers. Blocks start out as random bytes; headers and
    // payloads are then written over them. Writes past the current end of
    // the image are dropped.
    // ------------------------------------------------------------------------
    function automatic void start_image(input bit [7:0] ext);
        img.delete();
        repeat (128) img.push_back(8'($urandom));
        img[edidcid_pkg::EXT_COUNT_OFFSET] = ext;
    endfunction

    function automatic int add_block(input bit [7:0] tag, input bit [7:0] dlen);
        int base;
        base = img.size();
        repeat (128) img.push_back(8'($urandom));
        img[base]                          = tag;
        img[base + edidcid_pkg::LEN_OFFSET] = dlen;
        return base;
    endfunction

    function automatic void poke(input int idx, input bit [7:0] v);
        if (idx < img.size())
            img[idx] = v;
    endfunction

    // Writes a data block header and returns the index of its payload.
    function automatic int add_header(input int at, input bit [7:0] tag, input int plen);
        poke(at, tag);
        poke(at + 1, 8'($urandom));
        poke(at + 2, 8'(plen));
        return at + 3;
    endfunction

    function automatic void fill_payload(input int at, input int n, input bit zero);
        for (int k = 0; k < n; k++)
            poke(at + k, zero ? 8'd0 : 8'($urandom));
    endfunction

    // A short random image that ends before the extension area.
    function automatic void short_image();
        img.delete();
        repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Sender tasks. Every request is driven at the falling edge and counted
    // as accepted at the rising edge where in_ready is seen high. The valid
    // line is lowered only on an idle gap or once a stretch of traffic ends.
    // ------------------------------------------------------------------------
    task automatic push_byte(input bit [7:0] b, input bit is_last);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        edid_byte <= b;
        last      <= is_last;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        id_board.note_byte(b, is_last);
    endtask

    task automatic send_image();
        for (int i = 0; i < img.size(); i++)
            push_byte(img[i], i == img.size() - 1);
    endtask

    // Stop offering requests and wait until every expected report is back.
    task automatic drain_reports();
        @(negedge clk);
        in_valid <= 1'b0;
        while (id_board.waiting() > 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int b;
        int pay;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Tiny images: a single byte with last set, both extremes.
        img.delete();
        img.push_back(8'hFF);
        send_image();
        img.delete();
        img.push_back(8'h00);
        send_image();

        // One DisplayID block: a Container ID payload of 15 bytes is too
        // short, an all-zero one is passed over, and the next one is found.
        start_image(8'd1);
        b   = add_block(edidcid_pkg::TAG_DISPLAYID, 8'd122);
        pay = add_header(b + edidcid_pkg::FIRST_HEADER, edidcid_pkg::TAG_CONTAINER_ID, 15);
        fill_payload(pay, 15, 1'b0);
        pay = add_header(pay + 15, edidcid_pkg::TAG_CONTAINER_ID, 20);
        fill_payload(pay, 20, 1'b1);
        pay = add_header(pay + 20, edidcid_pkg::TAG_CONTAINER_ID, 16);
        fill_payload(pay, 16, 1'b0);
        img[pay]      = 8'hFF;
        img[pay + 15] = 8'h01;
        send_image();
        drain_reports();

        // Hold the receiver off for a long stretch while tiny images keep
        // coming, so a held report plus a second last byte stalls the input.
        long_stall_req = ~long_stall_req;
        repeat (8) begin
            img.delete();
            repeat ($urandom_range(1, 3)) img.push_back(8'($urandom));
            send_image();
        end
        drain_reports();

        // Short random images in four phases of idling; each phase ends with
        // the sender paused until every report is back.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 16 : 0;
            recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 16 : 0;
            repeat (8) begin
                short_image();
                send_image();
            end
            drain_reports();
        end

        // Let any stray report show before the final check.
        repeat (10) @(posedge clk);
        if (id_board.errors == 0 && id_board.waiting() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with every stall at its longest.
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
